>>> src/wlcm_pkg.sv
// Shared constants, register codes and types for the wrench limit cancel monitor.
// Used by every module under src; depends on nothing.
package wlcm_pkg;

  // Sample geometry
  localparam int SAMPLE_WIDTH = 24;
  localparam int AXES         = 3;
  localparam int IN_BITS      = 2 * AXES * SAMPLE_WIDTH;
  localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W        = 8;

  // Magnitude arithmetic widths; the sum of three squares still fits in SQ_W
  localparam int SQ_W     = 2 * SAMPLE_WIDTH;
  localparam int LIM_W    = 24;
  localparam int LIM_SQ_W = 2 * LIM_W;
  localparam int CMP_W    = (SQ_W > LIM_SQ_W) ? SQ_W : LIM_SQ_W;

  // Counter widths
  localparam int BURST_W = 8;
  localparam int HOLD_W  = 16;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_FORCE_USER    = 3'd0;
  localparam logic [IDX_W-1:0] REG_TORQUE_USER   = 3'd1;
  localparam logic [IDX_W-1:0] REG_FORCE_BIASED  = 3'd2;
  localparam logic [IDX_W-1:0] REG_TORQUE_BIASED = 3'd3;
  localparam logic [IDX_W-1:0] REG_BIAS_ACTIVE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_CANCEL_BURST  = 3'd5;
  localparam logic [IDX_W-1:0] REG_HOLDOFF       = 3'd6;

  // Reset values
  localparam logic [LIM_W-1:0]   RST_FORCE_USER    = 24'd12800;
  localparam logic [LIM_W-1:0]   RST_TORQUE_USER   = 24'd1280;
  localparam logic [LIM_W-1:0]   RST_FORCE_BIASED  = 24'd2560;
  localparam logic [LIM_W-1:0]   RST_TORQUE_BIASED = 24'd205;
  localparam logic [BURST_W-1:0] RST_CANCEL_BURST  = 8'd5;
  localparam logic [HOLD_W-1:0]  RST_HOLDOFF       = 16'd100;

  // Stage advance strobes shared by both lanes
  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } stage_en_t;

  // Squared limits and counter settings seen by the merge stage
  typedef struct packed {
    logic [LIM_SQ_W-1:0] force_user_sq;
    logic [LIM_SQ_W-1:0] torque_user_sq;
    logic [LIM_SQ_W-1:0] force_biased_sq;
    logic [LIM_SQ_W-1:0] torque_biased_sq;
    logic [BURST_W-1:0]  cancel_burst;
    logic [HOLD_W-1:0]   holdoff_length;
  } limits_t;

endpackage

>>> src/wlcm_lane.sv
// One magnitude lane: absolute value, squares and sum of three axes.
// Depends on wlcm_pkg; stage strobes come from the top level.
module wlcm_lane (
  input  logic                                        clk,
  input  wlcm_pkg::stage_en_t                         en,
  input  logic [wlcm_pkg::AXES*wlcm_pkg::SAMPLE_WIDTH-1:0] axes,
  output logic [wlcm_pkg::SQ_W-1:0]                   sq_sum
);

  logic [wlcm_pkg::SAMPLE_WIDTH-1:0] mag [wlcm_pkg::AXES];
  logic [wlcm_pkg::SQ_W-1:0]         sq  [wlcm_pkg::AXES];
  logic [wlcm_pkg::SQ_W+1:0]         sum_wide;

  // Take the magnitude of each axis; the most negative code maps to 2^(W-1)
  always_ff @(posedge clk) begin
    if (en.adv1) begin
      for (int i = 0; i < wlcm_pkg::AXES; i++) begin
        if (axes[i*wlcm_pkg::SAMPLE_WIDTH + wlcm_pkg::SAMPLE_WIDTH - 1]) begin
          mag[i] <= ~axes[i*wlcm_pkg::SAMPLE_WIDTH +: wlcm_pkg::SAMPLE_WIDTH]
                    + wlcm_pkg::SAMPLE_WIDTH'(1);
        end else begin
          mag[i] <= axes[i*wlcm_pkg::SAMPLE_WIDTH +: wlcm_pkg::SAMPLE_WIDTH];
        end
      end
    end
  end

  // Square each magnitude, one multiplier per axis
  always_ff @(posedge clk) begin
    if (en.adv2) begin
      for (int i = 0; i < wlcm_pkg::AXES; i++) begin
        sq[i] <= {{wlcm_pkg::SAMPLE_WIDTH{1'b0}}, mag[i]}
               * {{wlcm_pkg::SAMPLE_WIDTH{1'b0}}, mag[i]};
      end
    end
  end

  // Add the three squares; the total never exceeds SQ_W bits
  assign sum_wide = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

  always_ff @(posedge clk) begin
    if (en.adv3) begin
      sq_sum <= sum_wide[wlcm_pkg::SQ_W-1:0];
    end
  end

endmodule

>>> src/wlcm_regs.sv
// Configuration register file on the APB port, squared limits and fresh-bias flag.
// Depends on wlcm_pkg.
module wlcm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wlcm_pkg::ADDR_W-1:0] paddr,
  input  logic [wlcm_pkg::DATA_W-1:0] pwdata,
  output logic [wlcm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        take,
  output logic                        biased_sel,
  output wlcm_pkg::limits_t           limits
);

  logic [wlcm_pkg::LIM_W-1:0]   force_limit_user;
  logic [wlcm_pkg::LIM_W-1:0]   torque_limit_user;
  logic [wlcm_pkg::LIM_W-1:0]   force_limit_biased;
  logic [wlcm_pkg::LIM_W-1:0]   torque_limit_biased;
  logic                         bias_active;
  logic                         fresh_bias;
  logic [wlcm_pkg::BURST_W-1:0] cancel_burst;
  logic [wlcm_pkg::HOLD_W-1:0]  holdoff_length;
  logic                         wr_en;
  logic [wlcm_pkg::IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[wlcm_pkg::ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      force_limit_user    <= wlcm_pkg::RST_FORCE_USER;
      torque_limit_user   <= wlcm_pkg::RST_TORQUE_USER;
      force_limit_biased  <= wlcm_pkg::RST_FORCE_BIASED;
      torque_limit_biased <= wlcm_pkg::RST_TORQUE_BIASED;
      bias_active         <= 1'b0;
      cancel_burst        <= wlcm_pkg::RST_CANCEL_BURST;
      holdoff_length      <= wlcm_pkg::RST_HOLDOFF;
    end else if (wr_en) begin
      unique case (idx)
        wlcm_pkg::REG_FORCE_USER:    force_limit_user    <= pwdata[wlcm_pkg::LIM_W-1:0];
        wlcm_pkg::REG_TORQUE_USER:   torque_limit_user   <= pwdata[wlcm_pkg::LIM_W-1:0];
        wlcm_pkg::REG_FORCE_BIASED:  force_limit_biased  <= pwdata[wlcm_pkg::LIM_W-1:0];
        wlcm_pkg::REG_TORQUE_BIASED: torque_limit_biased <= pwdata[wlcm_pkg::LIM_W-1:0];
        wlcm_pkg::REG_BIAS_ACTIVE:   bias_active         <= pwdata[0];
        wlcm_pkg::REG_CANCEL_BURST:  cancel_burst        <= pwdata[wlcm_pkg::BURST_W-1:0];
        wlcm_pkg::REG_HOLDOFF:       holdoff_length      <= pwdata[wlcm_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Set fresh bias on a write of one; the first sample under bias clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_bias <= 1'b0;
    end else if (wr_en && idx == wlcm_pkg::REG_BIAS_ACTIVE && pwdata[0]) begin
      fresh_bias <= 1'b1;
    end else if (take && bias_active) begin
      fresh_bias <= 1'b0;
    end
  end

  assign biased_sel = bias_active & ~fresh_bias;

  // Square the limits and copy the counter settings; the user must keep settings static
  // while samples are in flight, as the block does not enforce it
  always_ff @(posedge clk) begin
    limits.force_user_sq    <= {{wlcm_pkg::LIM_W{1'b0}}, force_limit_user}
                             * {{wlcm_pkg::LIM_W{1'b0}}, force_limit_user};
    limits.torque_user_sq   <= {{wlcm_pkg::LIM_W{1'b0}}, torque_limit_user}
                             * {{wlcm_pkg::LIM_W{1'b0}}, torque_limit_user};
    limits.force_biased_sq  <= {{wlcm_pkg::LIM_W{1'b0}}, force_limit_biased}
                             * {{wlcm_pkg::LIM_W{1'b0}}, force_limit_biased};
    limits.torque_biased_sq <= {{wlcm_pkg::LIM_W{1'b0}}, torque_limit_biased}
                             * {{wlcm_pkg::LIM_W{1'b0}}, torque_limit_biased};
    limits.cancel_burst     <= cancel_burst;
    limits.holdoff_length   <= holdoff_length;
  end

  // Read back
  always_comb begin
    unique case (idx)
      wlcm_pkg::REG_FORCE_USER:    prdata = wlcm_pkg::DATA_W'(force_limit_user);
      wlcm_pkg::REG_TORQUE_USER:   prdata = wlcm_pkg::DATA_W'(torque_limit_user);
      wlcm_pkg::REG_FORCE_BIASED:  prdata = wlcm_pkg::DATA_W'(force_limit_biased);
      wlcm_pkg::REG_TORQUE_BIASED: prdata = wlcm_pkg::DATA_W'(torque_limit_biased);
      wlcm_pkg::REG_BIAS_ACTIVE:   prdata = wlcm_pkg::DATA_W'(bias_active);
      wlcm_pkg::REG_CANCEL_BURST:  prdata = wlcm_pkg::DATA_W'(cancel_burst);
      wlcm_pkg::REG_HOLDOFF:       prdata = wlcm_pkg::DATA_W'(holdoff_length);
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> src/wlcm_merge.sv
// Merge stage: compares both lane sums with the selected limits and runs the
// cancel burst / hold-off counters. Depends on wlcm_pkg.
module wlcm_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic [wlcm_pkg::SQ_W-1:0] force_sq,
  input  logic [wlcm_pkg::SQ_W-1:0] torque_sq,
  input  logic                      biased,
  input  wlcm_pkg::limits_t         limits,
  output logic                      cancel,
  output logic                      limit_exceeded,
  output logic                      biased_limits_used
);

  logic [wlcm_pkg::BURST_W-1:0] cancels_left, cancels_left_next;
  logic [wlcm_pkg::HOLD_W-1:0]  holdoff_left, holdoff_left_next;
  logic                         cancel_flag, cancel_flag_next;
  logic [wlcm_pkg::LIM_SQ_W-1:0] f_lim, t_lim;
  logic                         over;

  // Pick the limits and compare
  assign f_lim = biased ? limits.force_biased_sq  : limits.force_user_sq;
  assign t_lim = biased ? limits.torque_biased_sq : limits.torque_user_sq;
  assign over  = (wlcm_pkg::CMP_W'(force_sq)  > wlcm_pkg::CMP_W'(f_lim))
               | (wlcm_pkg::CMP_W'(torque_sq) > wlcm_pkg::CMP_W'(t_lim));

  // Burst, hold-off and re-arm decision
  always_comb begin
    cancels_left_next = cancels_left;
    holdoff_left_next = holdoff_left;
    cancel_flag_next  = cancel_flag;
    if (over && cancels_left != '0) begin
      cancel_flag_next  = 1'b1;
      cancels_left_next = cancels_left - wlcm_pkg::BURST_W'(1);
    end else if (cancels_left == '0 && holdoff_left != '0 &&
                 holdoff_left <= limits.holdoff_length) begin
      cancel_flag_next  = 1'b0;
      holdoff_left_next = holdoff_left - wlcm_pkg::HOLD_W'(1);
    end else if (holdoff_left == '0 || !over) begin
      cancel_flag_next  = 1'b0;
      cancels_left_next = limits.cancel_burst;
      holdoff_left_next = limits.holdoff_length;
    end
  end

  // Advance the counters once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      cancels_left <= wlcm_pkg::RST_CANCEL_BURST;
      holdoff_left <= wlcm_pkg::RST_HOLDOFF;
      cancel_flag  <= 1'b0;
    end else if (adv) begin
      cancels_left <= cancels_left_next;
      holdoff_left <= holdoff_left_next;
      cancel_flag  <= cancel_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv) begin
      cancel             <= cancel_flag_next;
      limit_exceeded     <= over;
      biased_limits_used <= biased;
    end
  end

endmodule

>>> src/wrench_limit_cancel_monitor_top.sv
// Path: an accepted sample passes the abs, square and sum registers of each lane
// and the merge result register to m_tdata. Throughput: one sample per cycle
// unless m_tready stalls; the three-stage abs/square/sum pipeline of each lane
// and the merge register each take one sample a cycle.
// Reset (rst, synchronous) empties the pipeline, loads register defaults and
// re-arms the counters. Depends on wlcm_pkg, wlcm_lane, wlcm_regs, wlcm_merge.
module wrench_limit_cancel_monitor_top (
  input  logic                        clk,
  input  logic                        rst,
  // s_tdata: force_x, force_y, force_z, torque_x, torque_y, torque_z
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [wlcm_pkg::IN_W-1:0]   s_tdata,
  // m_tdata: cancel, limit_exceeded, biased_limits_used, zero fill
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [wlcm_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wlcm_pkg::ADDR_W-1:0] paddr,
  input  logic [wlcm_pkg::DATA_W-1:0] pwdata,
  output logic [wlcm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int HALF = wlcm_pkg::AXES * wlcm_pkg::SAMPLE_WIDTH;

  wlcm_pkg::stage_en_t          en;
  wlcm_pkg::limits_t            limits;
  logic                         v1, v2, v3, v4;
  logic                         rdy1, rdy2, rdy3, rdy4;
  logic                         b1, b2, b3;
  logic                         accept, merge_adv, biased_sel;
  logic [wlcm_pkg::SQ_W-1:0]    force_sq, torque_sq;
  logic                         cancel, limit_exceeded, biased_limits_used;

  // Stage handshakes: a stage moves when the one after it has room
  assign rdy4      = ~v4 | m_tready;
  assign rdy3      = ~v3 | rdy4;
  assign rdy2      = ~v2 | rdy3;
  assign rdy1      = ~v1 | rdy2;
  assign s_tready  = rdy1 & ~rst;
  assign accept    = s_tvalid & s_tready;
  assign en.adv1   = accept;
  assign en.adv2   = v1 & rdy2;
  assign en.adv3   = v2 & rdy3;
  assign merge_adv = v3 & rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= accept;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Carry the limit selection alongside the sample
  always_ff @(posedge clk) begin
    if (en.adv1) b1 <= biased_sel;
    if (en.adv2) b2 <= b1;
    if (en.adv3) b3 <= b2;
  end

  wlcm_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .take       (accept),
    .biased_sel (biased_sel),
    .limits     (limits)
  );

  wlcm_lane u_force_lane (
    .clk    (clk),
    .en     (en),
    .axes   (s_tdata[HALF-1:0]),
    .sq_sum (force_sq)
  );

  wlcm_lane u_torque_lane (
    .clk    (clk),
    .en     (en),
    .axes   (s_tdata[2*HALF-1:HALF]),
    .sq_sum (torque_sq)
  );

  wlcm_merge u_merge (
    .clk                (clk),
    .rst                (rst),
    .adv                (merge_adv),
    .force_sq           (force_sq),
    .torque_sq          (torque_sq),
    .biased             (b3),
    .limits             (limits),
    .cancel             (cancel),
    .limit_exceeded     (limit_exceeded),
    .biased_limits_used (biased_limits_used)
  );

  assign m_tvalid = v4;
  assign m_tdata  = {{(wlcm_pkg::OUT_W-3){1'b0}}, biased_limits_used, limit_exceeded, cancel};

endmodule

>>> tb/wrench_limit_cancel_monitor_top_test.sv
// Self-checking testbench for the wrench limit cancel monitor top level.
// Drives sample streams and APB register writes, predicts every result in place.
// Depends on wlcm_pkg and wrench_limit_cancel_monitor_top.
module wrench_limit_cancel_monitor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One six-axis sample, force_x in the lowest bits
  typedef struct packed {
    logic signed [wlcm_pkg::SAMPLE_WIDTH-1:0] tz;
    logic signed [wlcm_pkg::SAMPLE_WIDTH-1:0] ty;
    logic signed [wlcm_pkg::SAMPLE_WIDTH-1:0] tx;
    logic signed [wlcm_pkg::SAMPLE_WIDTH-1:0] fz;
    logic signed [wlcm_pkg::SAMPLE_WIDTH-1:0] fy;
    logic signed [wlcm_pkg::SAMPLE_WIDTH-1:0] fx;
  } wrench_t;

  // Result bits, cancel in bit 0
  typedef struct packed {
    logic biased;
    logic exceeded;
    logic cancel;
  } verdict_t;

  localparam int AXIS_MAX = (1 << (wlcm_pkg::SAMPLE_WIDTH - 1)) - 1;
  localparam int AXIS_MIN = -(1 << (wlcm_pkg::SAMPLE_WIDTH - 1));

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [wlcm_pkg::IN_W-1:0]     s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [wlcm_pkg::OUT_W-1:0]    m_tdata;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [wlcm_pkg::ADDR_W-1:0]   paddr;
  logic [wlcm_pkg::DATA_W-1:0]   pwdata;
  logic [wlcm_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // Predictor copy of the registers
  logic [wlcm_pkg::LIM_W-1:0]    lim_force_user;
  logic [wlcm_pkg::LIM_W-1:0]    lim_torque_user;
  logic [wlcm_pkg::LIM_W-1:0]    lim_force_bias;
  logic [wlcm_pkg::LIM_W-1:0]    lim_torque_bias;
  logic                          bias_on;
  logic [wlcm_pkg::BURST_W-1:0]  burst_len;
  logic [wlcm_pkg::HOLD_W-1:0]   holdoff_len;

  // Predictor copy of the counters and flags
  logic [wlcm_pkg::BURST_W-1:0]  shots_left;
  logic [wlcm_pkg::HOLD_W-1:0]   quiet_left;
  logic                          cancel_q;
  logic                          bias_pending;

  verdict_t                      verdict_q[$];
  int                            error_count;
  int                            send_idle_pct;
  int                            recv_stall_pct;
  logic                          surge;

  wrench_limit_cancel_monitor_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Sum of squares of three signed axes, exact in 64 bits
  function automatic longint unsigned square_sum3(
    logic signed [wlcm_pkg::SAMPLE_WIDTH-1:0] a,
    logic signed [wlcm_pkg::SAMPLE_WIDTH-1:0] b,
    logic signed [wlcm_pkg::SAMPLE_WIDTH-1:0] c);
    longint sa;
    longint sb;
    longint sc;
    sa = a;
    sb = b;
    sc = c;
    if (sa < 0) sa = -sa;
    if (sb < 0) sb = -sb;
    if (sc < 0) sc = -sc;
    return longint'(sa * sa) + longint'(sb * sb) + longint'(sc * sc);
  endfunction

  // Advance the predicted monitor state by one sample
  function automatic verdict_t predict_cancel(wrench_t w);
    longint unsigned f_sq;
    longint unsigned t_sq;
    longint unsigned f_cap;
    longint unsigned t_cap;
    logic            use_bias;
    logic            over;
    verdict_t        v;
    f_sq = square_sum3(w.fx, w.fy, w.fz);
    t_sq = square_sum3(w.tx, w.ty, w.tz);
    use_bias = bias_on && !bias_pending;
    if (!use_bias && bias_on) bias_pending = 1'b0;
    f_cap = use_bias ? lim_force_bias : lim_force_user;
    t_cap = use_bias ? lim_torque_bias : lim_torque_user;
    over = (f_sq > f_cap * f_cap) || (t_sq > t_cap * t_cap);
    if (over && shots_left != 0) begin
      cancel_q = 1'b1;
      shots_left = shots_left - 1'b1;
    end else if (shots_left == 0 && quiet_left != 0 && quiet_left <= holdoff_len) begin
      cancel_q = 1'b0;
      quiet_left = quiet_left - 1'b1;
    end else if (quiet_left == 0 || !over) begin
      cancel_q = 1'b0;
      shots_left = burst_len;
      quiet_left = holdoff_len;
    end
    v.cancel = cancel_q;
    v.exceeded = over;
    v.biased = use_bias;
    return v;
  endfunction

  function automatic wrench_t pack_wrench(int fx, int fy, int fz, int tx, int ty, int tz);
    wrench_t w;
    w.fx = fx[wlcm_pkg::SAMPLE_WIDTH-1:0];
    w.fy = fy[wlcm_pkg::SAMPLE_WIDTH-1:0];
    w.fz = fz[wlcm_pkg::SAMPLE_WIDTH-1:0];
    w.tx = tx[wlcm_pkg::SAMPLE_WIDTH-1:0];
    w.ty = ty[wlcm_pkg::SAMPLE_WIDTH-1:0];
    w.tz = tz[wlcm_pkg::SAMPLE_WIDTH-1:0];
    return w;
  endfunction

  // Random axis value within +-bound, sign chosen at random
  function automatic int random_axis(int unsigned bound);
    int unsigned mag;
    if (bound > AXIS_MAX) bound = AXIS_MAX;
    mag = $urandom_range(0, bound);
    return $urandom_range(0, 1) ? -int'(mag) : int'(mag);
  endfunction

  function automatic int extreme_axis();
    case ($urandom_range(0, 4))
      0: return AXIS_MIN;
      1: return AXIS_MAX;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Sample shaped around the limits now selected: runs of overruns and quiet runs
  function automatic wrench_t random_wrench();
    int unsigned flim;
    int unsigned tlim;
    int unsigned fb;
    int unsigned tb;
    int          roll;
    wrench_t     w;
    flim = (bias_on && !bias_pending) ? lim_force_bias : lim_force_user;
    tlim = (bias_on && !bias_pending) ? lim_torque_bias : lim_torque_user;
    if ($urandom_range(0, 5) == 0) surge = !surge;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      w = wlcm_pkg::IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    end else if (roll < 9) begin
      w = pack_wrench(extreme_axis(), extreme_axis(), extreme_axis(),
                      extreme_axis(), extreme_axis(), extreme_axis());
    end else begin
      if (surge) begin
        fb = flim;
        tb = $urandom_range(0, 1) ? tlim + tlim / 4 : tlim / 2;
      end else begin
        fb = flim / 2;
        tb = tlim / 2;
      end
      w = pack_wrench(random_axis(fb), random_axis(fb), random_axis(fb),
                      random_axis(tb), random_axis(tb), random_axis(tb));
    end
    return w;
  endfunction

  // Fill the bits above a register with junk now and then
  function automatic logic [wlcm_pkg::DATA_W-1:0] pad_junk(
    logic [wlcm_pkg::DATA_W-1:0] value, int width);
    if ($urandom_range(0, 3) == 0) value = value | ($urandom() << width);
    return value;
  endfunction

  function automatic logic [wlcm_pkg::DATA_W-1:0] random_limit();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return (1 << wlcm_pkg::LIM_W) - 1;
      default: return $urandom_range(50, 30000);
    endcase
  endfunction

  // Drop valid and wait until every outstanding result has come back
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write: setup, then access; update the predictor once it lands
  task automatic reg_write(logic [wlcm_pkg::IDX_W-1:0] idx,
                           logic [wlcm_pkg::DATA_W-1:0] value);
    wait_idle();
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      wlcm_pkg::REG_FORCE_USER:    lim_force_user = value[wlcm_pkg::LIM_W-1:0];
      wlcm_pkg::REG_TORQUE_USER:   lim_torque_user = value[wlcm_pkg::LIM_W-1:0];
      wlcm_pkg::REG_FORCE_BIASED:  lim_force_bias = value[wlcm_pkg::LIM_W-1:0];
      wlcm_pkg::REG_TORQUE_BIASED: lim_torque_bias = value[wlcm_pkg::LIM_W-1:0];
      wlcm_pkg::REG_BIAS_ACTIVE: begin
        bias_on = value[0];
        if (value[0]) bias_pending = 1'b1;
      end
      wlcm_pkg::REG_CANCEL_BURST:  burst_len = value[wlcm_pkg::BURST_W-1:0];
      wlcm_pkg::REG_HOLDOFF:       holdoff_len = value[wlcm_pkg::HOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Offer one sample, wait for the transaction, record its expected result
  task automatic send_sample(wrench_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = wlcm_pkg::IN_W'(w);
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    verdict_q = {verdict_q, predict_cancel(w)};
  endtask

  // Axis extremes and magnitudes right at the default user limits
  task automatic test_boundaries();
    send_sample(pack_wrench(0, 0, 0, 0, 0, 0));
    send_sample(pack_wrench(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN));
    send_sample(pack_wrench(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX));
    send_sample(pack_wrench(12800, 0, 0, 0, 0, 0));
    send_sample(pack_wrench(0, -12801, 0, 0, 0, 0));
    send_sample(pack_wrench(0, 0, 0, 0, 0, 1280));
    send_sample(pack_wrench(0, 0, 0, -1281, 0, 0));
    // each axis below the limit, the vector sum just above it
    send_sample(pack_wrench(9051, -9051, 0, 0, 0, 0));
    send_sample(pack_wrench(-1, 1, -1, 1, -1, 1));
  endtask

  // Lower the hold-off below a loaded counter so no branch applies
  task automatic test_holdoff_lowered();
    send_sample(pack_wrench(0, 0, 0, 0, 0, 0));
    repeat (6) send_sample(pack_wrench(20000, 0, 0, 0, 0, 0));
    reg_write(wlcm_pkg::REG_HOLDOFF, 32'd3);
    send_sample(pack_wrench(0, 20000, 0, 0, 0, 0));
    send_sample(pack_wrench(0, 0, 0, 0, 0, 0));
  endtask

  // First sample after setting bias uses user limits, later ones the biased ones
  task automatic test_bias_switch();
    reg_write(wlcm_pkg::REG_BIAS_ACTIVE, 32'd1);
    send_sample(pack_wrench(5000, 0, 0, 0, 0, 0));
    send_sample(pack_wrench(5000, 0, 0, 0, 0, 0));
    reg_write(wlcm_pkg::REG_BIAS_ACTIVE, 32'd0);
    reg_write(wlcm_pkg::REG_BIAS_ACTIVE, 32'd1);
    send_sample(pack_wrench(0, 0, 5000, 0, 0, 0));
    reg_write(wlcm_pkg::REG_BIAS_ACTIVE, 32'd0);
  endtask

  // Zero limits, zero burst via an oversized write, short hold-off
  task automatic test_zero_settings();
    reg_write(wlcm_pkg::REG_FORCE_USER, 32'd0);
    reg_write(wlcm_pkg::REG_TORQUE_USER, 32'd0);
    reg_write(wlcm_pkg::REG_FORCE_BIASED, 32'd0);
    reg_write(wlcm_pkg::REG_TORQUE_BIASED, 32'd0);
    reg_write(wlcm_pkg::REG_CANCEL_BURST, 32'hFFFF_FF00);
    reg_write(wlcm_pkg::REG_HOLDOFF, 32'hABCD_0002);
    send_sample(pack_wrench(0, 0, 0, 0, 0, 0));
    send_sample(pack_wrench(1, 0, 0, 0, 0, 0));
    send_sample(pack_wrench(0, 0, 0, 0, -1, 0));
    send_sample(pack_wrench(0, 0, 0, 0, 0, 1));
  endtask

  // One random phase: fresh settings, then a shaped sample stream
  task automatic test_random_traffic(int phase, int items);
    logic [wlcm_pkg::DATA_W-1:0] burst;
    logic [wlcm_pkg::DATA_W-1:0] holdoff;
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default: begin send_idle_pct = 8; recv_stall_pct = 8; end
    endcase
    reg_write(wlcm_pkg::REG_FORCE_USER, pad_junk(random_limit(), wlcm_pkg::LIM_W));
    reg_write(wlcm_pkg::REG_TORQUE_USER, pad_junk(random_limit(), wlcm_pkg::LIM_W));
    reg_write(wlcm_pkg::REG_FORCE_BIASED, pad_junk(random_limit(), wlcm_pkg::LIM_W));
    reg_write(wlcm_pkg::REG_TORQUE_BIASED, pad_junk(random_limit(), wlcm_pkg::LIM_W));
    if (phase == 6) begin
      burst = (1 << wlcm_pkg::BURST_W) - 1;
      holdoff = (1 << wlcm_pkg::HOLD_W) - 1;
    end else if (phase == 7) begin
      burst = 0;
      holdoff = 0;
    end else begin
      burst = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 6);
      holdoff = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 12);
    end
    reg_write(wlcm_pkg::REG_CANCEL_BURST, pad_junk(burst, wlcm_pkg::BURST_W));
    reg_write(wlcm_pkg::REG_HOLDOFF, pad_junk(holdoff, wlcm_pkg::HOLD_W));
    reg_write(wlcm_pkg::REG_BIAS_ACTIVE, pad_junk($urandom_range(0, 1), 1));
    repeat (items) send_sample(random_wrench());
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result transaction: m_tdata %0h", m_tdata);
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want.cancel) begin
          $error("cancel: expected %0d, got %0d", want.cancel, m_tdata[0]);
          error_count++;
        end
        if (m_tdata[1] !== want.exceeded) begin
          $error("limit_exceeded: expected %0d, got %0d", want.exceeded, m_tdata[1]);
          error_count++;
        end
        if (m_tdata[2] !== want.biased) begin
          $error("biased_limits_used: expected %0d, got %0d", want.biased, m_tdata[2]);
          error_count++;
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    surge = 1'b0;
    lim_force_user = wlcm_pkg::RST_FORCE_USER;
    lim_torque_user = wlcm_pkg::RST_TORQUE_USER;
    lim_force_bias = wlcm_pkg::RST_FORCE_BIASED;
    lim_torque_bias = wlcm_pkg::RST_TORQUE_BIASED;
    bias_on = 1'b0;
    burst_len = wlcm_pkg::RST_CANCEL_BURST;
    holdoff_len = wlcm_pkg::RST_HOLDOFF;
    shots_left = wlcm_pkg::RST_CANCEL_BURST;
    quiet_left = wlcm_pkg::RST_HOLDOFF;
    cancel_q = 1'b0;
    bias_pending = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_boundaries();
    test_holdoff_lowered();
    test_bias_switch();
    test_zero_settings();
    for (int phase = 0; phase < 8; phase++) test_random_traffic(phase, 97);

    // Drain and let the pipeline settle before the verdict
    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
src/wlcm_pkg.sv
src/wlcm_lane.sv
src/wlcm_regs.sv
src/wlcm_merge.sv
src/wrench_limit_cancel_monitor_top.sv
tb/wrench_limit_cancel_monitor_top_test.sv
